>>> src/xcrc_pkg.sv
// Shared types, constants and helpers of the XMODEM-CRC block receiver.
// No dependencies; every other file but xcrc_ram imports this package.
`timescale 1ns / 1ps
package xcrc_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int WORDS       = BLOCK_BYTES / 4;
   localparam int BYTE_CNT_W  = $clog2(BLOCK_BYTES);
   localparam int WORD_AW     = $clog2(WORDS);

   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [7:0]  MAX_RETRIES_RESET = 8'd10;
   localparam logic [15:0] CRC_POLY          = 16'h1021;
   localparam logic [8:0]  CMP_SUM           = 9'h0FF;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_QUIET   = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CANCEL  = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_SEQ     = 3'd3;
   localparam logic [2:0] ST_RETRIES = 3'd4;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        data_valid;
      logic [31:0] data_word;
      logic [31:0] byte_offset;
      logic        done_res;
      logic [2:0]  status;
      logic        last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      JOB_ONE    = 3'b001,
      JOB_CANCEL = 3'b010,
      JOB_BLOCK  = 3'b100
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         tx_valid;
      logic [7:0]   tx_byte;
      logic         done;
      logic [2:0]   status;
      logic [31:0]  offset;
   } job_type;

   function automatic job_type job_one(input logic txv, input logic [7:0] txb,
                                       input logic done, input logic [2:0] st,
                                       input logic [31:0] off);
      job_type j;
      j.kind     = JOB_ONE;
      j.tx_valid = txv;
      j.tx_byte  = txb;
      j.done     = done;
      j.status   = st;
      j.offset   = off;
      return j;
   endfunction

   function automatic job_type job_cancel(input logic [2:0] st);
      job_type j;
      j.kind     = JOB_CANCEL;
      j.tx_valid = 1'b1;
      j.tx_byte  = CH_CAN;
      j.done     = 1'b1;
      j.status   = st;
      j.offset   = 32'd0;
      return j;
   endfunction

   function automatic job_type job_block(input logic [31:0] off);
      job_type j;
      j.kind     = JOB_BLOCK;
      j.tx_valid = 1'b1;
      j.tx_byte  = CH_ACK;
      j.done     = 1'b0;
      j.status   = ST_OK;
      j.offset   = off;
      return j;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> src/xcrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module xcrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/xcrc_job_fifo.sv
// Two-entry job queue between the protocol front and the result sequencer.
// Depends on xcrc_pkg.
`timescale 1ns / 1ps
module xcrc_job_fifo
   import xcrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  job_type data_i,
   output logic    full_o,
   input  logic    pop_i,
   output logic    valid_o,
   output job_type data_o
);
   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full_o  = (count_ff == 2'd2);
   assign valid_o = (count_ff != 2'd0);
   assign data_o  = mem_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && valid_o;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

   count_range_a: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("job queue count out of range");
   no_overflow_a: assert property (@(posedge clock) disable iff (reset)
      (full_o && !do_pop) |=> full_o)
      else $error("job queue lost an entry while full");
   pop_moves_a: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("job queue count did not drop on pop");
endmodule

>>> src/xcrc_front.sv
// Protocol front: classifies commands and bytes, checks block framing and CRC,
// stores block words in the RAM and queues jobs. Depends on xcrc_pkg.
`timescale 1ns / 1ps
module xcrc_front
   import xcrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  req_item_type          req_item,
   output logic                  full,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  q_full_i,
   output logic                  q_push_o,
   output job_type               q_data_o,
   input  logic                  blk_done_i,
   output logic                  wr_en_o,
   output logic [WORD_AW-1:0]    wr_addr_o,
   output logic [31:0]           wr_data_o
);
   typedef enum logic [10:0] {
      PH_IDLE       = 11'b000_0000_0001,
      PH_FLUSH_REQ  = 11'b000_0000_0010,
      PH_REQ_WAIT   = 11'b000_0000_0100,
      PH_BLK_NUM    = 11'b000_0000_1000,
      PH_BLK_CMP    = 11'b000_0001_0000,
      PH_DATA       = 11'b000_0010_0000,
      PH_CRC_HI     = 11'b000_0100_0000,
      PH_CRC_LO     = 11'b000_1000_0000,
      PH_WAIT_NEXT  = 11'b001_0000_0000,
      PH_FLUSH_NAK  = 11'b010_0000_0000,
      PH_RETRY_WAIT = 11'b100_0000_0000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [BYTE_CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]            block_number_ff, block_number_in;
   logic [7:0]            expected_ff, expected_in;
   logic [7:0]            retry_ff, retry_in;
   logic [7:0]            request_ff, request_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            crc_high_ff, crc_high_in;
   logic [31:0]           total_ff, total_in;
   logic [7:0]            max_retries_ff, max_retries_in;
   logic                  blk_busy_ff, blk_busy_in;
   logic [23:0]           shift_ff, shift_in;

   logic       accept;
   logic [7:0] b;
   logic [7:0] req_next, retry_next;
   logic [8:0] cmp_sum;

   assign full     = q_full_i || blk_busy_ff;
   assign accept   = push && !full;
   assign b        = req_item.rx_byte;
   assign req_next = request_ff + 8'd1;
   assign retry_next = retry_ff + 8'd1;
   assign cmp_sum  = {1'b0, block_number_ff} + {1'b0, b};

   assign wr_addr_o = byte_count_ff[BYTE_CNT_W-1:2];
   assign wr_data_o = {shift_ff, b};

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      block_number_in = block_number_ff;
      expected_in     = expected_ff;
      retry_in        = retry_ff;
      request_in      = request_ff;
      crc_in          = crc_ff;
      crc_high_in     = crc_high_ff;
      total_in        = total_ff;
      shift_in        = shift_ff;
      max_retries_in  = csr_wr_en ? csr_wr_data : max_retries_ff;
      blk_busy_in     = blk_done_i ? 1'b0 : blk_busy_ff;
      q_push_o        = 1'b0;
      q_data_o        = job_one(1'b0, 8'h00, 1'b0, ST_OK, 32'd0);
      wr_en_o         = 1'b0;

      if (accept) begin
         case (req_item.command)
            CMD_START: begin
               expected_in   = 8'd1;
               retry_in      = 8'd0;
               request_in    = 8'd0;
               total_in      = 32'd0;
               byte_count_in = '0;
               crc_in        = 16'd0;
               if (max_retries_ff == 8'd0) begin
                  q_push_o = 1'b1;
                  q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 32'd0);
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_FLUSH_REQ;
               end
            end
            CMD_QUIET: begin
               if (phase_ff == PH_FLUSH_REQ) begin
                  q_push_o = 1'b1;
                  q_data_o = job_one(1'b1, CH_C, 1'b0, ST_OK, 32'd0);
                  phase_in = PH_REQ_WAIT;
               end else if (phase_ff == PH_FLUSH_NAK) begin
                  q_push_o = 1'b1;
                  q_data_o = job_one(1'b1, CH_NAK, 1'b0, ST_OK, 32'd0);
                  phase_in = PH_RETRY_WAIT;
               end
            end
            CMD_TIMEOUT: begin
               case (phase_ff)
                  PH_REQ_WAIT: begin
                     request_in = req_next;
                     if (req_next >= max_retries_ff) begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 32'd0);
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_FLUSH_REQ;
                     end
                  end
                  PH_BLK_NUM, PH_BLK_CMP, PH_DATA, PH_CRC_HI, PH_CRC_LO: begin
                     retry_in = retry_next;
                     if (retry_next >= max_retries_ff) begin
                        q_push_o = 1'b1;
                        q_data_o = job_cancel(ST_RETRIES);
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_FLUSH_NAK;
                     end
                  end
                  PH_WAIT_NEXT: begin
                     q_push_o = 1'b1;
                     q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 32'd0);
                     phase_in = PH_IDLE;
                  end
                  PH_RETRY_WAIT: begin
                     phase_in = PH_BLK_NUM;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               case (phase_ff)
                  PH_REQ_WAIT: begin
                     if (b == CH_SOH) begin
                        retry_in = 8'd0;
                        phase_in = PH_BLK_NUM;
                     end else if (b == CH_EOT) begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b1, CH_ACK, 1'b1, ST_OK, total_ff);
                        phase_in = PH_IDLE;
                     end else if (b == CH_CAN) begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_CANCEL, 32'd0);
                        phase_in = PH_IDLE;
                     end else begin
                        request_in = req_next;
                        if (req_next >= max_retries_ff) begin
                           q_push_o = 1'b1;
                           q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 32'd0);
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_FLUSH_REQ;
                        end
                     end
                  end
                  PH_BLK_NUM: begin
                     block_number_in = b;
                     phase_in        = PH_BLK_CMP;
                  end
                  PH_BLK_CMP: begin
                     if (cmp_sum != CMP_SUM) begin
                        retry_in = retry_next;
                        if (retry_next >= max_retries_ff) begin
                           q_push_o = 1'b1;
                           q_data_o = job_cancel(ST_RETRIES);
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_FLUSH_NAK;
                        end
                     end else begin
                        byte_count_in = '0;
                        crc_in        = 16'd0;
                        phase_in      = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     shift_in      = {shift_ff[15:0], b};
                     wr_en_o       = (byte_count_ff[1:0] == 2'b11);
                     crc_in        = crc_byte(crc_ff, b);
                     byte_count_in = byte_count_ff + 1'b1;
                     if (byte_count_ff == BYTE_CNT_W'(BLOCK_BYTES - 1)) begin
                        phase_in = PH_CRC_HI;
                     end
                  end
                  PH_CRC_HI: begin
                     crc_high_in = b;
                     phase_in    = PH_CRC_LO;
                  end
                  PH_CRC_LO: begin
                     if ({crc_high_ff, b} != crc_ff) begin
                        retry_in = retry_next;
                        if (retry_next >= max_retries_ff) begin
                           q_push_o = 1'b1;
                           q_data_o = job_cancel(ST_RETRIES);
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_FLUSH_NAK;
                        end
                     end else if (block_number_ff == expected_ff) begin
                        q_push_o    = 1'b1;
                        q_data_o    = job_block(total_ff);
                        blk_busy_in = 1'b1;
                        total_in    = total_ff + 32'(BLOCK_BYTES);
                        expected_in = expected_ff + 8'd1;
                        retry_in    = 8'd0;
                        phase_in    = PH_WAIT_NEXT;
                     end else if (block_number_ff != (expected_ff - 8'd1)) begin
                        q_push_o = 1'b1;
                        q_data_o = job_cancel(ST_SEQ);
                        phase_in = PH_IDLE;
                     end else begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b1, CH_ACK, 1'b0, ST_OK, 32'd0);
                        phase_in = PH_WAIT_NEXT;
                     end
                  end
                  PH_WAIT_NEXT, PH_RETRY_WAIT: begin
                     if (b == CH_SOH) begin
                        phase_in = PH_BLK_NUM;
                     end else if (b == CH_EOT) begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b1, CH_ACK, 1'b1, ST_OK, total_ff);
                        phase_in = PH_IDLE;
                     end else if (b == CH_CAN) begin
                        q_push_o = 1'b1;
                        q_data_o = job_one(1'b0, 8'h00, 1'b1, ST_CANCEL, 32'd0);
                        phase_in = PH_IDLE;
                     end else if (phase_ff == PH_WAIT_NEXT) begin
                        retry_in = retry_next;
                        if (retry_next >= max_retries_ff) begin
                           q_push_o = 1'b1;
                           q_data_o = job_cancel(ST_RETRIES);
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_FLUSH_NAK;
                        end
                     end else begin
                        phase_in = PH_BLK_NUM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         byte_count_ff   <= '0;
         block_number_ff <= 8'd0;
         expected_ff     <= 8'd1;
         retry_ff        <= 8'd0;
         request_ff      <= 8'd0;
         crc_ff          <= 16'd0;
         crc_high_ff     <= 8'd0;
         total_ff        <= 32'd0;
         max_retries_ff  <= MAX_RETRIES_RESET;
         blk_busy_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         block_number_ff <= block_number_in;
         expected_ff     <= expected_in;
         retry_ff        <= retry_in;
         request_ff      <= request_in;
         crc_ff          <= crc_in;
         crc_high_ff     <= crc_high_in;
         total_ff        <= total_in;
         max_retries_ff  <= max_retries_in;
         blk_busy_ff     <= blk_busy_in;
      end
      shift_ff <= shift_in;
   end

   busy_holds_a: assert property (@(posedge clock) disable iff (reset)
      (blk_busy_ff && !blk_done_i) |=> blk_busy_ff)
      else $error("block drain flag dropped early");
   block_push_sets_busy_a: assert property (@(posedge clock) disable iff (reset)
      (q_push_o && q_data_o.kind == JOB_BLOCK) |=> blk_busy_ff)
      else $error("block job queued without drain flag");
   no_write_when_busy_a: assert property (@(posedge clock) disable iff (reset)
      wr_en_o |-> !blk_busy_ff)
      else $error("block store written during drain");
endmodule

>>> src/xcrc_back.sv
// Result sequencer: turns queued jobs into result transfers, reading block
// words from the RAM. Depends on xcrc_pkg.
`timescale 1ns / 1ps
module xcrc_back
   import xcrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid_i,
   input  job_type            q_data_i,
   output logic               q_pop_o,
   output logic [WORD_AW-1:0] rd_addr_o,
   input  logic [31:0]        rd_data_i,
   output logic               blk_done_o,
   output logic               empty,
   output rsp_item_type       rsp_item,
   input  logic               pop
);
   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_RD   = 5'b00010,
      B_WORD = 5'b00100,
      B_ACK  = 5'b01000,
      B_CAN2 = 5'b10000
   } bstate_type;

   bstate_type         state_ff, state_in;
   job_type            job_ff, job_in;
   logic [WORD_AW-1:0] addr_ff, addr_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_ff, out_in;
   logic               out_can;
   rsp_item_type       blank;

   assign empty     = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign rd_addr_o = addr_ff;
   assign out_can   = !out_valid_ff || pop;
   assign blank     = '{default: '0};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      addr_in      = addr_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      q_pop_o      = 1'b0;
      blk_done_o   = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid_i && out_can) begin
               q_pop_o = 1'b1;
               job_in  = q_data_i;
               case (q_data_i.kind)
                  JOB_BLOCK: begin
                     addr_in  = '0;
                     state_in = B_RD;
                  end
                  JOB_CANCEL: begin
                     out_in          = blank;
                     out_in.tx_valid = 1'b1;
                     out_in.tx_byte  = CH_CAN;
                     out_valid_in    = 1'b1;
                     state_in        = B_CAN2;
                  end
                  default: begin
                     out_in             = blank;
                     out_in.tx_valid    = q_data_i.tx_valid;
                     out_in.tx_byte     = q_data_i.tx_byte;
                     out_in.byte_offset = q_data_i.offset;
                     out_in.done_res    = q_data_i.done;
                     out_in.status      = q_data_i.status;
                     out_in.last        = 1'b1;
                     out_valid_in       = 1'b1;
                  end
               endcase
            end
         end
         B_RD: begin
            state_in = B_WORD;
         end
         B_WORD: begin
            if (out_can) begin
               out_in             = blank;
               out_in.data_valid  = 1'b1;
               out_in.data_word   = rd_data_i;
               out_in.byte_offset = job_ff.offset + {{(30 - WORD_AW){1'b0}}, addr_ff, 2'b00};
               out_valid_in       = 1'b1;
               if (addr_ff == WORD_AW'(WORDS - 1)) begin
                  state_in = B_ACK;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = B_RD;
               end
            end
         end
         B_ACK: begin
            if (out_can) begin
               out_in          = blank;
               out_in.tx_valid = 1'b1;
               out_in.tx_byte  = CH_ACK;
               out_in.last     = 1'b1;
               out_valid_in    = 1'b1;
               blk_done_o      = 1'b1;
               state_in        = B_IDLE;
            end
         end
         B_CAN2: begin
            if (out_can) begin
               out_in          = blank;
               out_in.tx_valid = 1'b1;
               out_in.tx_byte  = CH_CAN;
               out_in.done_res = 1'b1;
               out_in.status   = job_ff.status;
               out_in.last     = 1'b1;
               out_valid_in    = 1'b1;
               state_in        = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff  <= job_in;
      addr_ff <= addr_in;
      out_ff  <= out_in;
   end

   rd_then_word_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RD) |=> (state_ff == B_WORD))
      else $error("read stage not followed by word stage");
   ack_is_block_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_ACK || state_ff == B_WORD) |-> (job_ff.kind == JOB_BLOCK))
      else $error("block sequence running for a non-block job");
   can2_is_cancel_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CAN2) |-> (job_ff.kind == JOB_CANCEL))
      else $error("cancel sequence running for a non-cancel job");
endmodule

>>> src/xmodem_crc_block_receiver_top.sv
// Top level of the XMODEM-CRC block receiver.
// Depends on xcrc_pkg, xcrc_front, xcrc_job_fifo, xcrc_ram and xcrc_back.
//
// Input queue: drive req_item and push; an item transfers when push is high
// and full is low. Commands: start, byte received, wait timeout, line quiet.
// Result queue: while empty is low, rsp_item holds the oldest result; pop
// takes it. The last flag marks the final result of one input item.
// Config: csr_wr_en with csr_wr_data writes max_retries (reset 10); write
// only while the block is idle.
// Flow: a byte or event is classified in the cycle it transfers; a single
// result passes the job queue and the result register. A good new block
// drains 32 data words and an ACK, each word read from the block RAM read
// port in a read state and a word state; full stays high until that ACK is
// loaded. Other items are accepted while the two-entry job queue has room.
// Reset: synchronous, active high; clears the protocol state, the queues and
// the result register. The block RAM holds no reset state.
// A stalled result side holds the current result; the front keeps taking
// items until the job queue fills.
`timescale 1ns / 1ps
module xmodem_crc_block_receiver_top
   import xcrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type req_item,
   output logic         full,
   output logic         empty,
   output rsp_item_type rsp_item,
   input  logic         pop,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);
   logic               q_full, q_push, q_pop, q_valid;
   job_type            q_wdata, q_rdata;
   logic               blk_done;
   logic               wr_en;
   logic [WORD_AW-1:0] wr_addr, rd_addr;
   logic [31:0]        wr_data, rd_data;

   xcrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_item    (req_item),
      .full        (full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full_i    (q_full),
      .q_push_o    (q_push),
      .q_data_o    (q_wdata),
      .blk_done_i  (blk_done),
      .wr_en_o     (wr_en),
      .wr_addr_o   (wr_addr),
      .wr_data_o   (wr_data)
   );

   xcrc_job_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .data_i  (q_wdata),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .data_o  (q_rdata)
   );

   xcrc_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   xcrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid_i  (q_valid),
      .q_data_i   (q_rdata),
      .q_pop_o    (q_pop),
      .rd_addr_o  (rd_addr),
      .rd_data_i  (rd_data),
      .blk_done_o (blk_done),
      .empty      (empty),
      .rsp_item   (rsp_item),
      .pop        (pop)
   );
endmodule

>>> tb/tb_xmodem_crc_block_receiver_top.sv
// Testbench for the XMODEM-CRC block receiver: drives start, byte, timeout and
// quiet events, predicts every result in a behavioral model and checks them.
// Depends on xcrc_pkg and xmodem_crc_block_receiver_top.
`timescale 1ns / 1ps
module tb_xmodem_crc_block_receiver_top;
   import xcrc_pkg::*;

   typedef enum logic [3:0] {
      P_IDLE, P_FLUSH_REQ, P_REQ_WAIT, P_BLK_NUM, P_BLK_CMP, P_DATA,
      P_CRC_HI, P_CRC_LO, P_WAIT_NEXT, P_FLUSH_NAK, P_RETRY_WAIT
   } rx_phase_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   req_item_type req_item = '0;
   logic         full;
   logic         empty;
   rsp_item_type rsp_item;
   logic         pop = 1'b0;
   logic         csr_wr_en = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   xmodem_crc_block_receiver_top i_dut (
      .clock(clock), .reset(reset), .push(push), .req_item(req_item), .full(full),
      .empty(empty), .rsp_item(rsp_item), .pop(pop), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // receiver model state
   logic [7:0]   m_max_retries;
   rx_phase_type m_phase;
   int unsigned  m_byte_count;
   logic [7:0]   m_blk_num, m_expected_blk, m_retry_count, m_request_count, m_crc_high;
   logic [15:0]  m_crc;
   logic [31:0]  m_store [WORDS];
   logic [31:0]  m_total;

   rsp_item_type expected_rsp_q[$];
   rsp_item_type step_q[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;
   bit  sink_stall = 0;
   bit  bursts_on = 1;

   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      return r;
   endfunction

   function automatic void add_rsp(input logic txv, input logic [7:0] txb, input logic dv,
                                   input logic [31:0] dw, input logic [31:0] off,
                                   input logic done, input logic [2:0] st);
      rsp_item_type r;
      r.tx_valid = txv; r.tx_byte = txb; r.data_valid = dv; r.data_word = dw;
      r.byte_offset = off; r.done_res = done; r.status = st; r.last = 1'b0;
      step_q.push_back(r);
   endfunction

   function automatic void end_transfer(input logic txv, input logic [7:0] txb,
                                        input logic [2:0] st);
      add_rsp(txv, txb, 1'b0, 32'd0, st == ST_OK ? m_total : 32'd0, 1'b1, st);
      m_phase = P_IDLE;
   endfunction

   function automatic void send_cancel(input logic [2:0] st);
      add_rsp(1'b1, CH_CAN, 1'b0, 32'd0, 32'd0, 1'b0, ST_OK);
      end_transfer(1'b1, CH_CAN, st);
   endfunction

   function automatic void count_request();
      m_request_count++;
      if (m_request_count >= m_max_retries) end_transfer(1'b0, 8'h00, ST_TIMEOUT);
      else m_phase = P_FLUSH_REQ;
   endfunction

   function automatic void count_block_retry();
      m_retry_count++;
      if (m_retry_count >= m_max_retries) send_cancel(ST_RETRIES);
      else m_phase = P_FLUSH_NAK;
   endfunction

   function automatic void close_block(input logic [7:0] lo);
      if ({m_crc_high, lo} != m_crc) begin
         count_block_retry();
         return;
      end
      if (m_blk_num == m_expected_blk) begin
         for (int w = 0; w < WORDS; w++)
            add_rsp(1'b0, 8'h00, 1'b1, m_store[w], m_total + 32'(w * 4), 1'b0, ST_OK);
         m_total += 32'(BLOCK_BYTES);
         m_expected_blk++;
         m_retry_count = '0;
      end else if (m_blk_num != m_expected_blk - 8'd1) begin
         send_cancel(ST_SEQ);
         return;
      end
      add_rsp(1'b1, CH_ACK, 1'b0, 32'd0, 32'd0, 1'b0, ST_OK);
      m_phase = P_WAIT_NEXT;
   endfunction

   function automatic void predict_receiver(input req_item_type it);
      logic [7:0] b;
      int w;
      b = it.rx_byte;
      step_q.delete();
      case (it.command)
         CMD_START: begin
            m_expected_blk = 8'd1; m_retry_count = '0; m_request_count = '0;
            m_total = '0; m_byte_count = 0; m_crc = '0;
            if (m_request_count >= m_max_retries) end_transfer(1'b0, 8'h00, ST_TIMEOUT);
            else m_phase = P_FLUSH_REQ;
         end
         CMD_QUIET: begin
            if (m_phase == P_FLUSH_REQ) begin
               add_rsp(1'b1, CH_C, 1'b0, 32'd0, 32'd0, 1'b0, ST_OK); m_phase = P_REQ_WAIT;
            end else if (m_phase == P_FLUSH_NAK) begin
               add_rsp(1'b1, CH_NAK, 1'b0, 32'd0, 32'd0, 1'b0, ST_OK); m_phase = P_RETRY_WAIT;
            end
         end
         CMD_TIMEOUT: begin
            case (m_phase)
               P_REQ_WAIT: count_request();
               P_BLK_NUM, P_BLK_CMP, P_DATA, P_CRC_HI, P_CRC_LO: count_block_retry();
               P_WAIT_NEXT: end_transfer(1'b0, 8'h00, ST_TIMEOUT);
               P_RETRY_WAIT: m_phase = P_BLK_NUM;
               default: ;
            endcase
         end
         default: begin
            case (m_phase)
               P_REQ_WAIT: begin
                  if (b == CH_SOH) begin
                     m_retry_count = '0; m_phase = P_BLK_NUM;
                  end else if (b == CH_EOT) end_transfer(1'b1, CH_ACK, ST_OK);
                  else if (b == CH_CAN) end_transfer(1'b0, 8'h00, ST_CANCEL);
                  else count_request();
               end
               P_BLK_NUM: begin
                  m_blk_num = b; m_phase = P_BLK_CMP;
               end
               P_BLK_CMP: begin
                  if ({1'b0, m_blk_num} + {1'b0, b} != 9'h0FF) count_block_retry();
                  else begin
                     m_byte_count = 0; m_crc = '0; m_phase = P_DATA;
                  end
               end
               P_DATA: begin
                  w = int'((m_byte_count >> 2) % WORDS);
                  m_store[w] = {m_store[w][23:0], b};
                  m_crc = crc_update(m_crc, b);
                  m_byte_count++;
                  if (m_byte_count >= BLOCK_BYTES) m_phase = P_CRC_HI;
               end
               P_CRC_HI: begin
                  m_crc_high = b; m_phase = P_CRC_LO;
               end
               P_CRC_LO: close_block(b);
               P_WAIT_NEXT, P_RETRY_WAIT: begin
                  if (b == CH_SOH) m_phase = P_BLK_NUM;
                  else if (b == CH_EOT) end_transfer(1'b1, CH_ACK, ST_OK);
                  else if (b == CH_CAN) end_transfer(1'b0, 8'h00, ST_CANCEL);
                  else if (m_phase == P_WAIT_NEXT) count_block_retry();
                  else m_phase = P_BLK_NUM;
               end
               default: ;
            endcase
         end
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_rsp_q.push_back(step_q[i]);
   endfunction

   // leaves push high after the transfer; idle phases drop it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      req_item_type it;
      it.command = cmd;
      it.rx_byte = b;
      if (bursts_on && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      predict_receiver(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_max_retries(input logic [7:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      m_max_retries = v;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(CMD_BYTE, b);
   endtask

   // handshake into a transfer: start, quiet -> 'C'
   task automatic open_transfer();
      send_item(CMD_START, 8'($urandom));
      send_item(CMD_QUIET, 8'($urandom));
   endtask

   // one block; corrupt: 0 good, 1 bad complement (header only), 2 bad crc
   task automatic send_block(input logic [7:0] num, input int corrupt, input bit rnd_data);
      logic [15:0] c;
      logic [7:0]  d;
      c = '0;
      send_byte(CH_SOH);
      send_byte(num);
      send_byte(corrupt == 1 ? num : ~num);
      if (corrupt == 1) return;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         d = rnd_data ? 8'($urandom) : (i[0] ? 8'hFF : 8'h00);
         c = crc_update(c, d);
         send_byte(d);
      end
      if (corrupt == 2) c ^= 16'h8000;
      send_byte(c[15:8]);
      send_byte(c[7:0]);
   endtask

   task automatic test_directed_requests();
      write_max_retries(8'd3);
      send_item(CMD_BYTE, 8'h55);
      send_item(CMD_TIMEOUT, 8'h00);
      send_item(CMD_QUIET, 8'h00);
      open_transfer();
      send_item(CMD_TIMEOUT, 8'hFF);
      send_byte(8'h77);
      send_item(CMD_QUIET, 8'h00);
      send_byte(8'hAA);
      send_item(CMD_QUIET, 8'h00);
      send_byte(8'hFF);
      open_transfer();
      send_byte(CH_CAN);
      open_transfer();
      send_byte(CH_EOT);
      write_max_retries(8'd0);
      send_item(CMD_START, 8'h00);
   endtask

   // good block under a long result stall, then a repeat of block number 1
   task automatic test_backpressure();
      write_max_retries(8'd255);
      open_transfer();
      sink_stall = 1;
      send_block(8'd1, 0, 1);
      sink_stall = 0;
      send_block(8'd1, 0, 0);
      send_byte(8'h99);
      send_item(CMD_QUIET, 8'h00);
      send_byte(CH_EOT);
      wait_drained();
   endtask

   task automatic test_block_errors();
      write_max_retries(8'd2);
      open_transfer();
      send_block(8'd1, 1, 1);
      send_item(CMD_QUIET, 8'h00);
      send_item(CMD_TIMEOUT, 8'h00);
      send_item(CMD_TIMEOUT, 8'h00);
      write_max_retries(8'd10);
      open_transfer();
      send_byte(CH_SOH);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h12);
      send_byte(8'h34);
      send_item(CMD_TIMEOUT, 8'h00);
      send_byte(8'h33);
      send_item(CMD_QUIET, 8'h00);
      send_byte(8'hCC);
      send_byte(8'h05);
      send_item(CMD_TIMEOUT, 8'h00);
      send_item(CMD_QUIET, 8'h00);
      send_item(CMD_TIMEOUT, 8'h00);
      send_byte(CH_CAN);
      send_item(CMD_TIMEOUT, 8'h00);
      send_item(CMD_QUIET, 8'h00);
      send_byte(CH_CAN);
   endtask

   task automatic test_random_sessions(input int n_items);
      int stop_at;
      int pick;
      logic [7:0] num;
      stop_at = items_sent + n_items;
      open_transfer();
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            num = 8'($urandom_range(0, 2));
            send_byte(CH_SOH);
            send_byte(num);
            send_byte($urandom_range(0, 1) ? ~num : 8'($urandom));
         end else if (pick < 7) begin
            send_item(CMD_QUIET, 8'($urandom));
            send_byte(CH_SOH);
         end else if (pick < 8) begin
            open_transfer();
         end else if (pick < 9) begin
            send_byte(CH_EOT);
            open_transfer();
         end else begin
            send_item(2'($urandom), 8'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (push && !full || pop && !empty) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            rsp_item_type e;
            e = expected_rsp_q.pop_front();
            if (rsp_item.tx_valid !== e.tx_valid) begin
               $error("tx_valid exp %0h got %0h", e.tx_valid, rsp_item.tx_valid); error_count++; end
            if (rsp_item.tx_byte !== e.tx_byte) begin
               $error("tx_byte exp %0h got %0h", e.tx_byte, rsp_item.tx_byte); error_count++; end
            if (rsp_item.data_valid !== e.data_valid) begin
               $error("data_valid exp %0h got %0h", e.data_valid, rsp_item.data_valid);
               error_count++; end
            if (rsp_item.data_word !== e.data_word) begin
               $error("data_word exp %0h got %0h", e.data_word, rsp_item.data_word);
               error_count++; end
            if (rsp_item.byte_offset !== e.byte_offset) begin
               $error("byte_offset exp %0h got %0h", e.byte_offset, rsp_item.byte_offset);
               error_count++; end
            if (rsp_item.done_res !== e.done_res) begin
               $error("done_res exp %0h got %0h", e.done_res, rsp_item.done_res); error_count++; end
            if (rsp_item.status !== e.status) begin
               $error("status exp %0h got %0h", e.status, rsp_item.status); error_count++; end
            if (rsp_item.last !== e.last) begin
               $error("last exp %0h got %0h", e.last, rsp_item.last); error_count++; end
         end
      end
   end

   // result side: random stall bursts; long hold-off while sink_stall is set
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         if (sink_stall) begin
            pop <= 1'b0;
            n = 0;
            while (n < 600) begin
               @(negedge clock);
               n++;
            end
            while (sink_stall) @(negedge clock);
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      m_max_retries = MAX_RETRIES_RESET;
      m_phase = P_IDLE; m_byte_count = 0; m_blk_num = '0; m_expected_blk = 8'd1;
      m_retry_count = '0; m_request_count = '0; m_crc = '0; m_crc_high = '0; m_total = '0;
      foreach (m_store[i]) m_store[i] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_requests();
      test_backpressure();
      test_block_errors();
      write_max_retries(8'd1);
      test_random_sessions(15);
      write_max_retries(8'd4);
      test_random_sessions(25);
      bursts_on = 0;
      write_max_retries(8'd10);
      test_random_sessions(20);
      wait_drained();
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
